### rtl/lcb_pkg.sv
// Shared types, constants and helpers for the breathing HSL color block.
// No dependencies.
package lcb_pkg;

  localparam int LIGHT_W = 17;
  localparam int PROD_W  = 35;

  localparam logic [15:0] THIRD_Q16      = 16'd21845;
  localparam logic [15:0] TWO_THIRDS_Q16 = 16'd43691;
  localparam logic [16:0] ONE_Q16        = 17'd65536;
  localparam logic [16:0] HALF_Q16       = 17'd32768;
  localparam logic [15:0] STEP_RESET     = 16'd197;
  localparam logic [15:0] PEAK_RESET     = 16'd32768;

  localparam logic REG_STEP = 1'b0;
  localparam logic REG_PEAK = 1'b1;

  typedef struct packed {
    logic        start;
    logic [11:0] num;
    logic [10:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [16:0] quo;
  } div_rsp_t;

  // Q1.16 value to a channel byte: (v * 255) >> 16, saturated.
  function automatic logic [7:0] to_byte(input logic [16:0] v);
    logic [24:0] x;
    begin
      x = {v, 8'b0} - {8'b0, v};
      to_byte = (x[24:16] > 9'd255) ? 8'hFF : x[23:16];
    end
  endfunction

endpackage

### rtl/led_color_breathing_hsl.sv
// Top level of the breathing HSL color block: APB registers, lightness stepper,
// sequencer, shared multiplier and one shared divider. Depends on lcb_pkg, lcb_div.
//
// Each accepted word with color in it keeps the input stalled through two divisions
// in the shared divider (start, 17 quotient bits, done), for saturation and then
// hue, and four passes through the one shared multiplier (lightness scaling, then
// one per channel), plus loading the output, which waits while the output register
// still holds a word that the receiver has not taken. A grey target skips the divider
// and the multiplier. Input stall is high from acceptance until the result has been
// loaded into the output register, which holds it until the receiver takes it.
module led_color_breathing_hsl (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] target_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] shown_color
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SAT  = 4'd1;
  localparam logic [3:0] S_SATW = 4'd2;
  localparam logic [3:0] S_HUE  = 4'd3;
  localparam logic [3:0] S_HUEW = 4'd4;
  localparam logic [3:0] S_Q    = 4'd5;
  localparam logic [3:0] S_QM   = 4'd6;
  localparam logic [3:0] S_QW   = 4'd7;
  localparam logic [3:0] S_CH   = 4'd8;
  localparam logic [3:0] S_CHM  = 4'd9;
  localparam logic [3:0] S_CHW  = 4'd10;
  localparam logic [3:0] S_GREY = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  localparam logic [1:0] RG_RISE = 2'd0;
  localparam logic [1:0] RG_TOP  = 2'd1;
  localparam logic [1:0] RG_FALL = 2'd2;
  localparam logic [1:0] RG_LOW  = 2'd3;

  logic [3:0]  state;
  logic [15:0] step;
  logic [15:0] peak;
  logic [lcb_pkg::LIGHT_W-1:0] light;
  logic        brighter;

  logic [7:0]  delta;
  logic [7:0]  den;
  logic [10:0] num;
  logic [10:0] six;
  logic [16:0] sat;
  logic [15:0] hue;
  logic [16:0] q;
  logic [16:0] p;
  logic [1:0]  idx;
  logic [1:0]  region;
  logic [16:0] mul_a;
  logic [17:0] mul_b;
  logic [lcb_pkg::PROD_W-1:0] prod;
  logic [23:0] color;

  lcb_pkg::div_req_t div_req;
  lcb_pkg::div_rsp_t div_rsp;

  logic        cfg_wr;
  logic        in_acc;
  logic [7:0]  cr, cg, cb, mx, mn, c_delta;
  logic [8:0]  c_sum, c_den;
  logic [10:0] c_six, c_num;
  logic [18:0] nxt;
  logic [18:0] pr16;
  logic [18:0] q_raw;
  logic [19:0] p_raw;
  logic [15:0] tt;
  logic [18:0] six_t;
  logic [18:0] fall_f;
  logic [18:0] lin_v;
  logic [16:0] ch_v;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign prdata   = (paddr[2] == lcb_pkg::REG_PEAK) ? {16'b0, peak} : {16'b0, step};
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= lcb_pkg::STEP_RESET;
      peak <= lcb_pkg::PEAK_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == lcb_pkg::REG_STEP) begin
        step <= pwdata[15:0];
      end else begin
        peak <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    cr = target_color[23:16];
    cg = target_color[15:8];
    cb = target_color[7:0];
    mx = cr;
    mn = cr;
    if (cg > mx) mx = cg;
    if (cb > mx) mx = cb;
    if (cg < mn) mn = cg;
    if (cb < mn) mn = cb;
    c_delta = mx - mn;
    c_sum   = {1'b0, mx} + {1'b0, mn};
    c_den   = (c_sum > 9'd255) ? 9'd510 - c_sum : c_sum;
    c_six   = {1'b0, c_delta, 2'b0} + {2'b0, c_delta, 1'b0};
    if (mx == cr) begin
      c_num = (cg >= cb) ? {3'b0, cg} - {3'b0, cb} : c_six + {3'b0, cg} - {3'b0, cb};
    end else if (mx == cg) begin
      c_num = {3'b0, cb} + {2'b0, c_delta, 1'b0} - {3'b0, cr};
    end else begin
      c_num = {3'b0, cr} + {1'b0, c_delta, 2'b0} - {3'b0, cg};
    end
    nxt = brighter ? {2'b0, light} + {3'b0, step} : {2'b0, light} - {3'b0, step};
  end

  always_comb begin
    pr16  = prod[34:16];
    if (light <= lcb_pkg::HALF_Q16) begin
      q_raw = pr16;
    end else begin
      q_raw = {2'b0, light} + {2'b0, sat} - pr16;
    end
    if (q_raw > {2'b0, lcb_pkg::ONE_Q16}) q_raw = {2'b0, lcb_pkg::ONE_Q16};
    p_raw = {2'b0, light, 1'b0} - {1'b0, q_raw};
    case (idx)
      2'd0:    tt = hue + lcb_pkg::THIRD_Q16;
      2'd1:    tt = hue;
      default: tt = hue + lcb_pkg::TWO_THIRDS_Q16;
    endcase
    six_t  = {1'b0, tt, 2'b0} + {2'b0, tt, 1'b0};
    fall_f = 19'd262144 - six_t;
    lin_v  = {2'b0, p} + pr16;
    case (region)
      RG_TOP:  ch_v = q;
      RG_LOW:  ch_v = p;
      default: ch_v = lin_v[16:0];
    endcase
  end

  always_comb begin
    div_req.start = (state == S_SAT) || (state == S_HUE);
    div_req.num   = (state == S_SAT) ? {4'b0, delta} : {1'b0, num};
    div_req.den   = (state == S_SAT) ? {3'b0, den} : six;
  end

  lcb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      light     <= '0;
      brighter  <= 1'b0;
      idx       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if ($signed(nxt) < 0) begin
              light    <= '0;
              brighter <= 1'b1;
            end else if ($signed(nxt) > $signed({3'b0, peak})) begin
              light    <= {1'b0, peak};
              brighter <= 1'b0;
            end else begin
              light <= nxt[16:0];
            end
            state <= (c_delta == 8'd0) ? S_GREY : S_SAT;
          end
        end
        S_SAT:  state <= S_SATW;
        S_SATW: if (div_rsp.done) state <= S_HUE;
        S_HUE:  state <= S_HUEW;
        S_HUEW: if (div_rsp.done) state <= S_Q;
        S_Q:    state <= S_QM;
        S_QM:   state <= S_QW;
        S_QW: begin
          idx   <= '0;
          state <= S_CH;
        end
        S_CH:   state <= S_CHM;
        S_CHM:  state <= S_CHW;
        S_CHW: begin
          idx   <= idx + 2'd1;
          state <= (idx == 2'd2) ? S_OUT : S_CH;
        end
        S_GREY: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        delta <= c_delta;
        den   <= c_den[7:0];
        num   <= c_num;
        six   <= c_six;
      end
      S_SATW: if (div_rsp.done) sat <= div_rsp.quo;
      S_HUEW: if (div_rsp.done) hue <= div_rsp.quo[16] ? 16'd0 : div_rsp.quo[15:0];
      S_Q: begin
        mul_a <= light;
        mul_b <= (light <= lcb_pkg::HALF_Q16) ? {1'b0, lcb_pkg::ONE_Q16} + {1'b0, sat}
                                             : {1'b0, sat};
      end
      S_QW: begin
        q <= q_raw[16:0];
        if (p_raw[19]) begin
          p <= '0;
        end else if (p_raw > {1'b0, q_raw}) begin
          p <= q_raw[16:0];
        end else begin
          p <= p_raw[16:0];
        end
      end
      S_CH: begin
        mul_a <= q - p;
        if (tt < 16'd10923) begin
          region <= RG_RISE;
          mul_b  <= six_t[17:0];
        end else if (tt < 16'd32768) begin
          region <= RG_TOP;
          mul_b  <= '0;
        end else if (tt < lcb_pkg::TWO_THIRDS_Q16) begin
          region <= RG_FALL;
          mul_b  <= fall_f[17:0];
        end else begin
          region <= RG_LOW;
          mul_b  <= '0;
        end
      end
      S_CHW:  color <= {color[15:0], lcb_pkg::to_byte(ch_v)};
      S_GREY: color <= {3{lcb_pkg::to_byte(light)}};
      S_OUT:  if (!out_valid || !out_stall) shown_color <= color;
      default: ;
    endcase
  end

endmodule

### rtl/lcb_div.sv
// Restoring divider producing 17 quotient bits of (num << 16) / den, one bit per cycle.
// Requires num < 2 * den. Depends on lcb_pkg.
module lcb_div (
  input  logic              clk,
  input  logic              rst,
  input  lcb_pkg::div_req_t req,
  output lcb_pkg::div_rsp_t rsp
);

  logic [11:0] rem;
  logic [10:0] den;
  logic [4:0]  cnt;
  logic [16:0] quo;
  logic        busy;
  logic        done;
  logic        ge;
  logic [11:0] rem_sub;

  assign ge      = rem >= {1'b0, den};
  assign rem_sub = ge ? rem - {1'b0, den} : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= {rem_sub[10:0], 1'b0};
      quo <= {quo[15:0], ge};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

### rtl/lcb_checker.sv
// Port-level checks for the breathing HSL color block, bound to its top level.
// Depends only on the top level's ports.
module lcb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] shown_color
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Input not stalled after a word was accepted.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(shown_color))
    else $error("Stalled output word changed or dropped.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid right after reset.");

  a_no_out_while_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall && !out_valid |=> !out_valid)
    else $error("Output word appeared without an accepted input word.");

endmodule

bind led_color_breathing_hsl lcb_checker u_lcb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .shown_color (shown_color)
);
